// ===== rtl/vdm_pkg.sv =====
// vdm_pkg: shared types and constants of the vandermonde erasure parity encoder
// no dependencies
`timescale 1ns / 1ps
package vdm_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_DATA   = 2'd0,
    REG_NUM_PARITY = 2'd1,
    REG_BLOCK_LEN  = 2'd2,
    REG_FIELD_POLY = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [4:0] block_index;
    logic [9:0] byte_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0] parity_row;
    logic [9:0] out_offset;
    logic [7:0] parity_byte;
    logic       last;
  } out_item_t;

  // token handed from cell to cell along the row chain
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       emit;
    logic       last;
    logic [2:0] row;
    logic [9:0] offset;
    logic [7:0] coef;
    logic [7:0] base;
    logic [7:0] data;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // one gf(2^8) multiply, bit 8 of the polynomial implied
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] poly);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = 8'd0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ poly) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

// ===== rtl/vdm_cell.sv =====
// vdm_cell: one parity-row cell, holds a slice of the parity store
// depends on vdm_pkg
`timescale 1ns / 1ps
module vdm_cell #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    poly,
  input  vdm_pkg::tok_t tok_in,
  output vdm_pkg::tok_t tok_out,
  output logic [7:0]    rd_byte
);
  import vdm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];
  logic [AW-1:0] addr;
  logic [7:0] newv;
  tok_t tok_r, tok_nxt;
  logic [7:0] rd_r;
  logic [7:0] rdata_r;
  logic [7:0] prod_r;
  logic [AW-1:0] waddr_r;
  logic first_r;
  logic wr_r;

  assign addr = AW'(tok_in.offset);
  assign newv = first_r ? prod_r : (rdata_r ^ prod_r);

  // read the entry as the transfer passes, write it back in the following cycle;
  // the updated value is the parity byte
  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      rdata_r <= mem[addr];
      prod_r  <= gf_mul(tok_in.coef, tok_in.data, poly);
      waddr_r <= addr;
      first_r <= tok_in.first;
    end
    if (wr_r) begin
      mem[waddr_r] <= newv;
      rd_r         <= newv;
    end
  end

  always_comb begin
    tok_nxt      = tok_in;
    tok_nxt.coef = gf_mul(tok_in.coef, tok_in.base, poly);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      wr_r  <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      wr_r  <= tok_in.valid;
    end
  end

  assign tok_out = tok_r;
  assign rd_byte = rd_r;

endmodule

// ===== rtl/vandermonde_erasure_parity_encoder.sv =====
// vandermonde_erasure_parity_encoder: top level, config, sequencer, cell row
// depends on vdm_pkg and vdm_cell
`timescale 1ns / 1ps
// Usage:
//  in_ channel: data byte tagged with block number and offset, taken when
//  in_valid is high and in_stall low. Bytes of block 0 overwrite the parity
//  entries, later blocks fold in. Blocks past the count or offsets past
//  block_len are dropped at once.
//  A byte travels down a row of one cell per parity row; each cell reads its
//  slice of the parity store, writes it back in the next cycle and passes the
//  next coefficient on. An item holds the input while it walks along the
//  cell row (m parity rows, up to 8); a dropped item does not stall the
//  input.
//  On the last block the finished bytes go to the out_ channel in row order,
//  one per cycle while the output is not stalled, last set on the final row;
//  such an item holds the input until its final row is in the output register.
//  The drain pauses while out_stall holds a valid transfer, the output register
//  holds its transfer.
//  Reset clears the sequencer and registers to their defaults; the store
//  itself is not cleared, block 0 writes it first.
//  cfg_: write enable, index, data; writes are registered before they take effect.
module vandermonde_erasure_parity_encoder #(
  parameter int unsigned MAX_DATA_BLOCKS   = 32,
  parameter int unsigned MAX_PARITY_BLOCKS = 8,
  parameter int unsigned MAX_BLOCK_LEN     = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vdm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vdm_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [vdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vdm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vdm_pkg::*;

  localparam int unsigned NCELL = (MAX_PARITY_BLOCKS < 8) ? MAX_PARITY_BLOCKS : 8;

  logic [5:0]  ndata_r;
  logic [3:0]  npar_r;
  logic [10:0] blen_r;
  logic [7:0]  poly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndata_r <= 6'd8;
      npar_r  <= 4'd4;
      blen_r  <= 11'd1024;
      poly_r  <= 8'h1d;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_DATA:   ndata_r <= cfg_wdata[5:0];
        REG_NUM_PARITY: npar_r  <= cfg_wdata[3:0];
        REG_BLOCK_LEN:  blen_r  <= cfg_wdata;
        REG_FIELD_POLY: poly_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // clamped working values
  logic [8:0]  n_c;
  logic [3:0]  m_c;
  logic [16:0] len_c;
  always_comb begin
    n_c = (ndata_r == 6'd0) ? 9'd1 : 9'(ndata_r);
    if (n_c > 9'(MAX_DATA_BLOCKS)) n_c = 9'(MAX_DATA_BLOCKS);
    m_c = (npar_r == 4'd0) ? 4'd1 : npar_r;
    if (m_c > 4'(NCELL)) m_c = 4'(NCELL);
    len_c = (blen_r == 11'd0) ? 17'd1 : 17'(blen_r);
    if (len_c > 17'(MAX_BLOCK_LEN)) len_c = 17'(MAX_BLOCK_LEN);
  end

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic emit_r, emit_nxt;
  logic hit;
  logic take;
  tok_t tok_head;
  tok_t chain [NCELL+1];
  logic [7:0] rd [NCELL];
  logic out_valid_r;
  out_item_t out_r;
  logic out_free;
  logic [9:0] off_r;

  assign take = in_valid && !in_stall;
  assign hit  = (9'(in_data.block_index) < n_c) && (17'(in_data.byte_offset) < len_c);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    emit_nxt  = emit_r;
    case (state_r)
      ST_IDLE: if (take && hit) begin
        state_nxt = ST_RUN;
        cnt_nxt   = 4'd0;
        emit_nxt  = (9'(in_data.block_index) == n_c - 9'd1);
      end
      ST_RUN: if (cnt_r == m_c - 4'd1) begin
        state_nxt = emit_r ? ST_DRAIN : ST_IDLE;
        cnt_nxt   = 4'd0;
      end else begin
        cnt_nxt = cnt_r + 4'd1;
      end
      ST_DRAIN: if (out_free) begin
        if (cnt_r == m_c - 4'd1) state_nxt = ST_IDLE;
        cnt_nxt = cnt_r + 4'd1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 4'd0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) off_r <= in_data.byte_offset;
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
  end

  always_comb begin
    tok_head        = '0;
    tok_head.valid  = take && hit;
    tok_head.first  = (in_data.block_index == 5'd0);
    tok_head.offset = in_data.byte_offset;
    tok_head.coef   = 8'd1;
    tok_head.base   = 8'(in_data.block_index) + 8'd1;
    tok_head.data   = in_data.data_byte;
  end

  assign chain[0] = tok_head;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    tok_t cin;
    // a cell past the row count sees no transfer
    always_comb begin
      cin = chain[g];
      if (4'(g) >= m_c) cin.valid = 1'b0;
    end
    vdm_cell #(.DEPTH(MAX_BLOCK_LEN)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .poly   (poly_r),
      .tok_in (cin),
      .tok_out(chain[g+1]),
      .rd_byte(rd[g])
    );
  end

  logic [2:0] sel;
  assign sel = cnt_r[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= (state_r == ST_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state_r == ST_DRAIN) begin
      out_r.parity_row  <= sel;
      out_r.out_offset  <= off_r;
      out_r.parity_byte <= rd[sel];
      out_r.last        <= (cnt_r == m_c - 4'd1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !take) else $error("item taken while busy");
  a_drain_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_DRAIN) |-> $past(state_r == ST_RUN))
    else $error("drain not after run");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data) && out_valid)
    else $error("stalled output changed");

endmodule

// ===== dv/vdm_parity_checker.sv =====
// vdm_parity_checker: watches the in_, out_ and cfg_ ports of the parity encoder,
// predicts the parity transfers and compares them; depends on vdm_pkg
`timescale 1ns / 1ps
module vdm_parity_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  vdm_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  vdm_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [vdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vdm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import vdm_pkg::*;

  localparam int ROWS = 8;
  localparam int DEPTH = 1024;

  logic [5:0]  num_data_q;
  logic [3:0]  num_parity_q;
  logic [10:0] block_len_q;
  logic [7:0]  poly_q;
  logic [7:0]  parity_mem [ROWS][DEPTH];
  out_item_t   parity_expected [$];

  function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b, logic [7:0] p);
    logic [7:0] sum;
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) sum ^= a;
      a = a[7] ? ((a << 1) ^ p) : (a << 1);
    end
    return sum;
  endfunction

  function automatic logic [7:0] gf_power(logic [7:0] b, int e, logic [7:0] p);
    logic [7:0] r;
    r = 8'd1;
    for (int k = 0; k < e; k++) r = gf_times(r, b, p);
    return r;
  endfunction

  // folds one data byte into the parity store, queues the finished rows on the last block
  task automatic fold_data_byte(in_item_t it);
    int n, m, len, j, off;
    logic [7:0] coef;
    out_item_t o;
    n   = (num_data_q == 0) ? 1 : (num_data_q > 32 ? 32 : num_data_q);
    m   = (num_parity_q == 0) ? 1 : (num_parity_q > ROWS ? ROWS : num_parity_q);
    len = (block_len_q == 0) ? 1 : (block_len_q > DEPTH ? DEPTH : block_len_q);
    j   = it.block_index;
    off = it.byte_offset;
    if (j >= n || off >= len) return;
    for (int i = 0; i < m; i++) begin
      coef = gf_times(gf_power(8'(j + 1), i, poly_q), it.data_byte, poly_q);
      parity_mem[i][off] = (j == 0) ? coef : (parity_mem[i][off] ^ coef);
    end
    if (j != n - 1) return;
    for (int i = 0; i < m; i++) begin
      o.parity_row  = 3'(i);
      o.out_offset  = 10'(off);
      o.parity_byte = parity_mem[i][off];
      o.last        = (i == m - 1);
      parity_expected = {parity_expected, o};
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    foreach (parity_mem[i, k]) parity_mem[i][k] = '0;
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      num_data_q   = 6'd8;
      num_parity_q = 4'd4;
      block_len_q  = 11'd1024;
      poly_q       = 8'h1d;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_NUM_DATA:   num_data_q   = cfg_wdata[5:0];
          REG_NUM_PARITY: num_parity_q = cfg_wdata[3:0];
          REG_BLOCK_LEN:  block_len_q  = cfg_wdata[10:0];
          REG_FIELD_POLY: poly_q       = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) fold_data_byte(in_data);
      if (out_valid && !out_stall) begin
        if (parity_expected.size() == 0) begin
          $error("unexpected parity transfer row %0d offset %0d", out_data.parity_row,
                 out_data.out_offset);
          fail_count++;
        end else begin
          e = parity_expected.pop_front();
          if (out_data.parity_row !== e.parity_row) begin
            $error("parity_row expected %0d actual %0d", e.parity_row, out_data.parity_row);
            fail_count++;
          end
          if (out_data.out_offset !== e.out_offset) begin
            $error("out_offset expected %0d actual %0d", e.out_offset, out_data.out_offset);
            fail_count++;
          end
          if (out_data.parity_byte !== e.parity_byte) begin
            $error("parity_byte expected %h actual %h", e.parity_byte, out_data.parity_byte);
            fail_count++;
          end
          if (out_data.last !== e.last) begin
            $error("last expected %b actual %b", e.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
    pending <= parity_expected.size();
  end
endmodule

// ===== dv/tb_vandermonde_erasure_parity_encoder.sv =====
// tb_vandermonde_erasure_parity_encoder: stimulus, reset and verdict for the parity encoder
// depends on vdm_pkg, the encoder rtl and vdm_parity_checker
`timescale 1ns / 1ps
module tb_vandermonde_erasure_parity_encoder;
  import vdm_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int fail_count;
  int pending;

  bit idle_on = 1'b1;
  int grp_n, grp_len;
  bit seeded [1024];
  int stall_left;

  always #6 clk = ~clk;

  vandermonde_erasure_parity_encoder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  vdm_parity_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver backpressure in short bursts
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(logic [7:0] b, int j, int off);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, block_index: j[4:0], byte_offset: off[9:0]};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // only between groups, once every parity transfer is out and the row has settled
  task automatic set_coding(int n, int m, int len, int poly);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    write_reg(REG_NUM_DATA, n);
    write_reg(REG_NUM_PARITY, m);
    write_reg(REG_BLOCK_LEN, len);
    write_reg(REG_FIELD_POLY, poly);
    cfg_we  <= 1'b0;
    grp_n   = (n % 64 == 0) ? 1 : (n % 64 > 32 ? 32 : n % 64);
    grp_len = (len % 2048 == 0) ? 1 : (len % 2048 > 1024 ? 1024 : len % 2048);
    foreach (seeded[k]) seeded[k] = 1'b0;
  endtask

  // block 0 first, the rest in order or shuffled, possibly cut short
  task automatic code_group(int off, bit shuffle, int count, int fixed_byte);
    int order [$];
    int a, t;
    for (int j = 1; j < grp_n; j++) order = {order, j};
    if (shuffle) begin
      for (int k = order.size() - 1; k > 0; k--) begin
        a = $urandom_range(0, k);
        t = order[k]; order[k] = order[a]; order[a] = t;
      end
    end
    send_byte(fixed_byte < 0 ? 8'($urandom) : 8'(fixed_byte), 0, off);
    seeded[off] = 1'b1;
    for (int k = 0; k < count - 1 && k < order.size(); k++)
      send_byte(fixed_byte < 0 ? 8'($urandom) : 8'(fixed_byte), order[k], off);
  endtask

  task automatic stray_byte();
    int pick, off;
    pick = $urandom_range(0, 2);
    if (pick == 0 && grp_n < 32)
      send_byte(8'($urandom), $urandom_range(grp_n, 31), $urandom_range(0, grp_len - 1));
    else if (pick == 1 && grp_len < 1024)
      send_byte(8'($urandom), $urandom_range(0, 31), $urandom_range(grp_len, 1023));
    else begin
      off = $urandom_range(0, grp_len - 1);
      if (seeded[off] && grp_n > 1) send_byte(8'($urandom), $urandom_range(1, grp_n - 1), off);
      else code_group(off, 1'b0, 1, -1);
    end
  endtask

  task automatic random_phase(int budget);
    int done, r, c;
    done = 0;
    while (done < budget) begin
      r = $urandom_range(0, 19);
      if (r < 15) begin
        code_group($urandom_range(0, grp_len - 1), $urandom_range(0, 3) == 0, grp_n, -1);
        done += grp_n;
      end else if (r < 17) begin
        c = $urandom_range(1, grp_n);
        code_group($urandom_range(0, grp_len - 1), 1'b1, c, -1);
        done += c;
      end else begin
        stray_byte();
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    grp_n     = 8;
    grp_len   = 1024;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: full group of ones, then blocks past the group
    code_group(0, 1'b0, 8, 255);
    send_byte(8'h5a, 31, 0);
    send_byte(8'h5a, 8, 1023);
    // single block, single row, one-byte blocks, zero polynomial
    set_coding(1, 1, 1, 0);
    send_byte(8'h80, 0, 0);
    send_byte(8'hff, 0, 1);
    send_byte(8'h01, 0, 1023);
    // widest rows, all-ones polynomial, top offset
    set_coding(2, 8, 1024, 255);
    code_group(1023, 1'b0, 2, 255);
    code_group(512, 1'b0, 2, 0);
    // out-of-range register values clamp: zeros to one, large values to the maximum
    set_coding(0, 0, 0, 29);
    send_byte(8'hc3, 0, 0);
    send_byte(8'hc3, 1, 0);
    set_coding(63, 15, 2047, 29);
    code_group(1023, 1'b0, 32, 255);

    set_coding(32, 8, 1024, 29);
    random_phase(110);
    set_coding(3, 8, 16, 8'h2b);
    random_phase(70);
    for (int p = 0; p < 3; p++) begin
      set_coding($urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 2047),
                 $urandom_range(0, 255));
      random_phase(45);
    end
    set_coding(5, 8, 1024, 8'h87);
    idle_on = 1'b0;
    random_phase(60);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("vandermonde_erasure_parity_encoder test passed");
    end else begin
      $display("vandermonde_erasure_parity_encoder test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("vandermonde_erasure_parity_encoder test failed");
    $finish;
  end
endmodule
